/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the passive-mode address parser.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ASSERT_NRST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_NRST_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_NRST(label, clk, rst_n, prop)
`define ASSERT_NRST_IMPL(label, clk, rst_n, pre, post)

`endif

`endif

/* hw/rtl/pmap_pkg.sv */
// Package of the passive-mode address parser: phase and radix codes,
// character constants and part limits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmap_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SEEK      = 3'd0,
    PH_ADDR      = 3'd1,
    PH_HI_FIRST  = 3'd2,
    PH_HI_DIGITS = 3'd3,
    PH_SKIP      = 3'd4,
    PH_LO_FIRST  = 3'd5,
    PH_LO_DIGITS = 3'd6,
    PH_DONE      = 3'd7
  } phase_e;

  // Radix of the address part being read
  typedef enum logic [1:0] {
    RADIX_DEC  = 2'd0,
    RADIX_OCT  = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_ZERO = 2'd3
  } radix_e;

  localparam logic [7:0] CHAR_OPEN    = 8'h28;  // '('
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;  // ','
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_EIGHT   = 8'h38;  // '8'
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;  // 'X'

  localparam logic [8:0] PART_LIMIT = 9'd256;
  localparam logic [1:0] PART_LAST  = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/passive_mode_address_parser.sv */
// Passive-mode reply address parser: character input register, parse state
// and result register. Depends on pmap_pkg and assert_macros.svh.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------
//   request  | valid_i, stall_o | character_i, final_char_i
//   result   | valid_o, stall_i | ok_o, ip_address_o, port_number_o
//
// One character is taken per cycle while stall_o is low; the parse state
// is registered. A result is valid once its final character has passed
// the input register and then the result register.
// Reset clears phase, counters, error flag and both valid flags.
// A stalled result holds only a final character in the input register;
// other characters keep flowing, so stall_o rises only in that case.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module passive_mode_address_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  character_i,
  input  wire logic        final_char_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             ok_o,
  output logic [31:0]      ip_address_o,
  output logic [15:0]      port_number_o
);
  import pmap_pkg::*;

  // Character decode helpers
  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    if (is_dec(c)) begin
      d = c[3:0];
    end else begin
      d = c[3:0] + 4'd9;  // 'a'/'A' have low nibble 1
    end
    return d;
  endfunction

  function automatic logic [8:0] sat_part(input logic [12:0] v);
    return (v > {4'd0, PART_LIMIT}) ? PART_LIMIT : v[8:0];
  endfunction

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_final_q;

  // Parse state
  phase_e      phase_q, phase_d;
  logic [1:0]  part_index_q, part_index_d;
  logic [8:0]  part_value_q, part_value_d;
  radix_e      part_radix_q, part_radix_d;
  logic        part_has_digit_q, part_has_digit_d;
  logic [31:0] address_q, address_d;
  logic [7:0]  port_high_q, port_high_d;
  logic [7:0]  port_low_q, port_low_d;
  logic        error_q, error_d;

  // Result register
  logic        out_valid_q;
  logic        ok_q, ok_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] port_q, port_d;

  logic out_free;
  logic s1_go;
  logic in_accept;

  // Handshake: a final character waits for a free result slot
  assign out_free  = !out_valid_q || !stall_i;
  assign s1_go     = s1_valid_q && (!s1_final_q || out_free);
  assign stall_o   = s1_valid_q && !s1_go;
  assign in_accept = valid_i && !stall_o;

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q  <= character_i;
      s1_final_q <= final_char_i;
    end
  end

  // Multiply-add candidates for the address part and the port bytes
  logic [12:0] acc_dec, acc_oct, acc_hex;
  logic [11:0] hi_mac, lo_mac;

  assign acc_dec = {1'b0, part_value_q, 3'd0} + {3'd0, part_value_q, 1'b0}
                 + {9'd0, s1_char_q[3:0]};
  assign acc_oct = {1'b0, part_value_q, 3'd0} + {9'd0, s1_char_q[3:0]};
  assign acc_hex = {part_value_q, 4'd0} + {9'd0, hex_digit(s1_char_q)};
  assign hi_mac  = {1'b0, port_high_q, 3'd0} + {3'd0, port_high_q, 1'b0}
                 + {8'd0, s1_char_q[3:0]};
  assign lo_mac  = {1'b0, port_low_q, 3'd0} + {3'd0, port_low_q, 1'b0}
                 + {8'd0, s1_char_q[3:0]};

  // Advance the parse state by one character
  always_comb begin
    phase_d          = phase_q;
    part_index_d     = part_index_q;
    part_value_d     = part_value_q;
    part_radix_d     = part_radix_q;
    part_has_digit_d = part_has_digit_q;
    address_d        = address_q;
    port_high_d      = port_high_q;
    port_low_d       = port_low_q;
    error_d          = error_q;

    if (!error_q) begin
      case (phase_q)
        PH_SEEK: begin
          if (s1_char_q == CHAR_OPEN) phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          if (!part_has_digit_q) begin
            if (!is_dec(s1_char_q)) begin
              error_d = 1'b1;
            end else begin
              part_has_digit_d = 1'b1;
              part_value_d     = {5'd0, s1_char_q[3:0]};
              part_radix_d     = (s1_char_q == CHAR_ZERO) ? RADIX_ZERO : RADIX_DEC;
            end
          end else if (s1_char_q == CHAR_COMMA) begin
            if (part_value_q >= PART_LIMIT) begin
              error_d = 1'b1;
            end else begin
              address_d        = {address_q[23:0], part_value_q[7:0]};
              part_value_d     = 9'd0;
              part_radix_d     = RADIX_DEC;
              part_has_digit_d = 1'b0;
              if (part_index_q == PART_LAST) begin
                part_index_d = 2'd0;
                phase_d      = PH_HI_FIRST;
              end else begin
                part_index_d = part_index_q + 2'd1;
              end
            end
          end else if (part_radix_q == RADIX_ZERO &&
                       (s1_char_q == CHAR_LOWER_X || s1_char_q == CHAR_UPPER_X)) begin
            part_radix_d = RADIX_HEX;
          end else if (part_radix_q == RADIX_HEX) begin
            if (!is_hex(s1_char_q)) error_d = 1'b1;
            else                    part_value_d = sat_part(acc_hex);
          end else if (!is_dec(s1_char_q)) begin
            error_d = 1'b1;
          end else if (part_radix_q == RADIX_DEC) begin
            part_value_d = sat_part(acc_dec);
          end else if (s1_char_q >= CHAR_EIGHT) begin
            // octal part, possibly just after the leading zero
            error_d = 1'b1;
          end else begin
            part_radix_d = RADIX_OCT;
            part_value_d = sat_part(acc_oct);
          end
        end
        PH_HI_FIRST: begin
          if (!is_dec(s1_char_q)) begin
            error_d = 1'b1;
          end else begin
            port_high_d = {4'd0, s1_char_q[3:0]};
            phase_d     = PH_HI_DIGITS;
          end
        end
        PH_HI_DIGITS: begin
          if (is_dec(s1_char_q)) begin
            port_high_d = hi_mac[7:0];
          end else begin
            phase_d = (s1_char_q == CHAR_COMMA) ? PH_LO_FIRST : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (s1_char_q == CHAR_COMMA) phase_d = PH_LO_FIRST;
        end
        PH_LO_FIRST: begin
          if (!is_dec(s1_char_q)) begin
            error_d = 1'b1;
          end else begin
            port_low_d = {4'd0, s1_char_q[3:0]};
            phase_d    = PH_LO_DIGITS;
          end
        end
        PH_LO_DIGITS: begin
          if (is_dec(s1_char_q)) port_low_d = lo_mac[7:0];
          else                   phase_d    = PH_DONE;
        end
        default: begin
        end
      endcase
    end

    // Form the result from the updated state; zero it on error or before the low port byte
    ok_d   = !error_d && (phase_d == PH_LO_DIGITS || phase_d == PH_DONE);
    ip_d   = ok_d ? address_d : 32'd0;
    port_d = ok_d ? {port_high_d, port_low_d} : 16'd0;
  end

  // Hold the parse state; return to reset after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_SEEK;
      part_index_q     <= 2'd0;
      part_value_q     <= 9'd0;
      part_radix_q     <= RADIX_DEC;
      part_has_digit_q <= 1'b0;
      address_q        <= 32'd0;
      port_high_q      <= 8'd0;
      port_low_q       <= 8'd0;
      error_q          <= 1'b0;
    end else if (s1_go) begin
      if (s1_final_q) begin
        phase_q          <= PH_SEEK;
        part_index_q     <= 2'd0;
        part_value_q     <= 9'd0;
        part_radix_q     <= RADIX_DEC;
        part_has_digit_q <= 1'b0;
        address_q        <= 32'd0;
        port_high_q      <= 8'd0;
        port_low_q       <= 8'd0;
        error_q          <= 1'b0;
      end else begin
        phase_q          <= phase_d;
        part_index_q     <= part_index_d;
        part_value_q     <= part_value_d;
        part_radix_q     <= part_radix_d;
        part_has_digit_q <= part_has_digit_d;
        address_q        <= address_d;
        port_high_q      <= port_high_d;
        port_low_q       <= port_low_d;
        error_q          <= error_d;
      end
    end
  end

  // Load the result register; drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_final_q) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_final_q) begin
      ok_q   <= ok_d;
      ip_q   <= ip_d;
      port_q <= port_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign ok_o          = ok_q;
  assign ip_address_o  = ip_q;
  assign port_number_o = port_q;

  // Checks
  `ASSERT_NRST_IMPL(a_err_result_zero, clk_i, rst_ni, valid_o && !ok_o,
                    ip_address_o == 32'd0 && port_number_o == 16'd0)
  `ASSERT_NRST(a_part_saturates, clk_i, rst_ni, part_value_q <= PART_LIMIT)
  `ASSERT_NRST_IMPL(a_final_waits, clk_i, rst_ni,
                    s1_valid_q && s1_final_q && valid_o && stall_i, stall_o)
  `ASSERT_NRST(a_reset_after_final, clk_i, rst_ni,
               (s1_go && s1_final_q) |=> (phase_q == PH_SEEK && !error_q))
  `ASSERT_NRST_IMPL(a_index_in_addr, clk_i, rst_ni, part_index_q != 2'd0,
                    phase_q == PH_ADDR)

endmodule

`default_nettype wire
